// ----- hdl/lcdw_pkg.sv -----
`default_nettype none
package lcdw_pkg;

  localparam int unsigned LCDW_QUEUE_DEPTH = 2;
  localparam int unsigned MAX_OPS          = 4;
  localparam int unsigned OP_IDX_W         = $clog2(MAX_OPS);

  localparam logic [7:0]  COL_MAX     = 8'd19;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;
  localparam logic [7:0]  ROW0_BASE   = 8'h80;
  localparam logic [7:0]  ROW1_BASE   = 8'h90;
  localparam logic [15:0] WIDE_LIMIT  = 16'd128;
  localparam logic [7:0]  FOLD_HIGH   = 8'hFF;
  localparam logic [15:0] FOLD_BASE   = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_RETURN  = 2'd1,
    CMD_SET_POS = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_INSTR = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [OP_IDX_W-1:0]  last_idx;
    op_t [MAX_OPS-1:0]    ops;
  } job_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } cur_t;

  typedef struct packed {
    logic empty;
    logic full;
    job_t head;
  } q_stat_t;

  function automatic cur_t cur_advance(cur_t c);
    cur_t r;
    r = c;
    r.col = c.col + 8'd1;
    if (r.col > COL_MAX) r.col = 8'd0;
    if (r.col == 8'd0) r.row = {7'd0, ~c.row[0]};
    return r;
  endfunction

  function automatic cur_t cur_normalize(cur_t c);
    cur_t r;
    r = c;
    if (r.col > COL_MAX) r.col = 8'd0;
    r.row = {7'd0, c.row[0]};
    return r;
  endfunction

  function automatic logic [7:0] pos_byte(cur_t c);
    logic [7:0] base;
    base = c.row[0] ? ROW1_BASE : ROW0_BASE;
    return base | {1'b0, c.col[7:1]};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lcdw_if.sv -----
`default_nettype none
interface lcdw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] char_code;
  logic [7:0]  read_byte;
  logic [7:0]  new_column;
  logic [7:0]  new_row;

  modport source (output valid, cmd, char_code, read_byte, new_column, new_row,
                  input ready);
  modport sink   (input valid, cmd, char_code, read_byte, new_column, new_row,
                  output ready);
endinterface

interface lcdw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] op_kind;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, op_kind, bus_byte, last, input ready);
  modport sink   (input valid, op_kind, bus_byte, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/lcdw_front.sv -----
`default_nettype none
module lcdw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lcdw_in_if.sink            in_ch,
  input  wire logic          q_full,
  output logic               push,
  output lcdw_pkg::job_t     push_job
);
  import lcdw_pkg::*;

  cur_t       cur_r, cur_nxt;
  logic       rp_r, rp_nxt;
  logic [7:0] pc_r, pc_nxt;
  logic       fire;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_t                c;
    job_t                j;
    logic [15:0]         code;
    logic [OP_IDX_W-1:0] n;
    c      = cur_r;
    j      = '0;
    code   = in_ch.char_code;
    n      = '0;
    push   = 1'b0;
    rp_nxt = rp_r;
    pc_nxt = pc_r;
    if (fire) begin
      unique case (cmd_t'(in_ch.cmd))
        CMD_PUT: begin
          rp_nxt = 1'b0;
          push   = 1'b1;
          if (code > WIDE_LIMIT) begin
            if (c.col[0]) begin
              j.ops[0] = '{kind: OP_WRITE, data: SPACE_CHAR};
              c = cur_advance(c);
              n = OP_IDX_W'(1);
            end
            c = cur_normalize(c);
            j.ops[n] = '{kind: OP_INSTR, data: pos_byte(c)};
            if (code[15:8] == FOLD_HIGH) code = FOLD_BASE - code;
            j.ops[n + OP_IDX_W'(1)] = '{kind: OP_WRITE, data: code[15:8]};
            c = cur_advance(c);
            j.ops[n + OP_IDX_W'(2)] = '{kind: OP_WRITE, data: code[7:0]};
            c = cur_advance(c);
            j.last_idx = n + OP_IDX_W'(2);
          end else begin
            c = cur_normalize(c);
            j.ops[0] = '{kind: OP_INSTR, data: pos_byte(c)};
            if (c.col[0]) begin
              j.ops[1]   = '{kind: OP_READ, data: 8'd0};
              j.last_idx = OP_IDX_W'(1);
              rp_nxt     = 1'b1;
              pc_nxt     = code[7:0];
            end else begin
              j.ops[1]   = '{kind: OP_WRITE, data: code[7:0]};
              j.ops[2]   = '{kind: OP_WRITE, data: SPACE_CHAR};
              j.last_idx = OP_IDX_W'(2);
              c = cur_advance(c);
            end
          end
        end
        CMD_RETURN: begin
          if (rp_r) begin
            rp_nxt     = 1'b0;
            push       = 1'b1;
            c          = cur_normalize(c);
            j.ops[0]   = '{kind: OP_INSTR, data: pos_byte(c)};
            j.ops[1]   = '{kind: OP_WRITE, data: in_ch.read_byte};
            j.ops[2]   = '{kind: OP_WRITE, data: pc_r};
            j.last_idx = OP_IDX_W'(2);
            c = cur_advance(c);
          end
        end
        CMD_SET_POS: begin
          rp_nxt = 1'b0;
          c.col  = in_ch.new_column;
          c.row  = in_ch.new_row;
        end
        default: ;
      endcase
    end
    cur_nxt  = c;
    push_job = j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      rp_r  <= 1'b0;
      pc_r  <= '0;
    end else begin
      cur_r <= cur_nxt;
      rp_r  <= rp_nxt;
      pc_r  <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lcdw_queue.sv -----
`default_nettype none
module lcdw_queue #(
  parameter int unsigned DEPTH = lcdw_pkg::LCDW_QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lcdw_pkg::job_t  push_job,
  input  wire logic            pop,
  output lcdw_pkg::q_stat_t    stat
);
  import lcdw_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hdl/lcdw_back.sv -----
`default_nettype none
module lcdw_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lcdw_pkg::q_stat_t  stat,
  output logic                    pop,
  lcdw_out_if.source              out_ch
);
  import lcdw_pkg::*;

  logic [OP_IDX_W-1:0] idx_r, idx_nxt;
  op_t                 op;
  logic                is_last;
  logic                xfer;

  assign op      = stat.head.ops[idx_r];
  assign is_last = (idx_r == stat.head.last_idx);
  assign xfer    = out_ch.valid && out_ch.ready;
  assign pop     = xfer && is_last;

  assign out_ch.valid    = !stat.empty;
  assign out_ch.op_kind  = op.kind;
  assign out_ch.bus_byte = op.data;
  assign out_ch.last     = is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) idx_nxt = is_last ? '0 : idx_r + OP_IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> idx_r <= stat.head.last_idx)
    else $error("op index past end of job");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == '0)
    else $error("op index not cleared after job");

endmodule
`default_nettype wire

// ----- hdl/lcd_text_cursor_writer_core.sv -----
// Character display text writer with a 20x2 cursor.
// in_ch : command transfers (put character, returned display byte, set cursor).
// out_ch: display-bus operations (instruction write, data write, read request);
//         last marks the final operation caused by one input transfer.
// The front end classifies each command and updates the cursor in the cycle
// it is accepted, then queues a job of two to four bus operations. Commands
// that cause nothing queue no job.
// Each job is registered in the queue; its first operation is offered once it
// reaches the head. The back end drives one operation per cycle while out_ch is
// ready; a character takes three or four operations (two for a read request).
// The input takes a command every cycle while the job queue (QDEPTH entries)
// has room. When out_ch stalls, the current operation holds and the queue
// fills; once full, in_ch.ready drops.
// Reset (synchronous, rst_n low): cursor at column 0 row 0, no read pending,
// queue empty.
`default_nettype none
module lcd_text_cursor_writer_core #(
  parameter int unsigned QDEPTH = lcdw_pkg::LCDW_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcdw_in_if.sink     in_ch,
  lcdw_out_if.source  out_ch
);
  import lcdw_pkg::*;

  logic    push;
  job_t    push_job;
  logic    pop;
  q_stat_t stat;

  lcdw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (stat.full),
    .push     (push),
    .push_job (push_job)
  );

  lcdw_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .stat     (stat)
  );

  lcdw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
